// ===== rtl/core/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the plucked-string voice core: register
// codes, reset values, field widths and the structs that feed the ring lanes.
// ----------------------------------------------------------------------------
package pss_pkg;

  // voice count is fixed by the register map
  localparam int VOICES     = 4;
  localparam int VOICE_BITS = 2;

  // field and register widths
  localparam int LEN_REG_W = 9;
  localparam int DAMP_W    = 16;
  localparam int GAIN_W    = 15;
  localparam int POS_W     = 8;
  localparam int EXC_W     = 16;
  localparam int OUT_W     = 16;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // operation codes of an input word
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PLUCK = 1'b1;

  // register index codes
  localparam logic [2:0] REG_LEN0 = 3'd0;
  localparam logic [2:0] REG_LEN1 = 3'd1;
  localparam logic [2:0] REG_LEN2 = 3'd2;
  localparam logic [2:0] REG_LEN3 = 3'd3;
  localparam logic [2:0] REG_DAMP = 3'd4;
  localparam logic [2:0] REG_GAIN = 3'd5;

  // register reset values
  localparam logic [LEN_REG_W-1:0] LEN0_RST = 9'd169;
  localparam logic [LEN_REG_W-1:0] LEN1_RST = 9'd134;
  localparam logic [LEN_REG_W-1:0] LEN2_RST = 9'd113;
  localparam logic [LEN_REG_W-1:0] LEN3_RST = 9'd89;
  localparam logic [DAMP_W-1:0]    DAMP_RST = 16'd32637;
  localparam logic [GAIN_W-1:0]    GAIN_RST = 15'd3277;

  // output saturation bound
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sd32767;

  // one word as seen by a single ring lane
  typedef struct packed {
    logic             tick;
    logic             pluck;
    logic [POS_W-1:0] position;
    logic [EXC_W-1:0] excitation;
  } issue_t;

  // pipeline control shared by all lanes
  typedef struct packed {
    logic accept;
    logic b_go;
    logic clr;
  } lane_ctl_t;

endpackage

// ===== rtl/core/pss_ring.sv =====
// ----------------------------------------------------------------------------
// pss_ring
// One voice: ring memory with two read ports and one write port, read
// pointer, write bypass and the damped two-tap feedback update.
// ----------------------------------------------------------------------------
module pss_ring import pss_pkg::*; #(
  parameter int MAX_LENGTH  = 256,
  parameter int SAMPLE_BITS = 16,
  localparam int PTR_W      = $clog2(MAX_LENGTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctl_t                     ctl,
  input  issue_t                        issue,
  input  logic [PTR_W-1:0]              clr_addr,
  input  logic [LEN_REG_W-1:0]          len_reg,
  input  logic [DAMP_W-1:0]             damping,
  output logic signed [SAMPLE_BITS-1:0] cur
);

  localparam int LW = PTR_W + 1;
  localparam int XW = SAMPLE_BITS + 18;
  localparam logic signed [XW-1:0] SMAX = XW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [XW-1:0] SMIN = ~SMAX;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [XW-1:0] x);
    logic signed [SAMPLE_BITS-1:0] r;
    priority if (x > SMAX) r = SAMPLE_BITS'(SMAX);
    else if (x < SMIN)     r = SAMPLE_BITS'(SMIN);
    else                   r = SAMPLE_BITS'(x);
    return r;
  endfunction

  logic signed [SAMPLE_BITS-1:0] mem [MAX_LENGTH];
  logic signed [SAMPLE_BITS-1:0] rd_cur, rd_nb;
  logic [PTR_W-1:0]              ptr, ptr_next;
  logic [LW-1:0]                 len_eff, nxt_full;
  logic [PTR_W-1:0]              pos_addr;

  // stage b word
  logic                          b_tick, b_wen;
  logic [PTR_W-1:0]              b_waddr;
  logic signed [SAMPLE_BITS-1:0] b_xdata;

  logic signed [SAMPLE_BITS:0]   pair;
  logic signed [XW-1:0]          prod;
  logic signed [SAMPLE_BITS-1:0] upd, bdata, wdata;
  logic                          we, fwd_cur, fwd_nb;
  logic [PTR_W-1:0]              waddr;

  // effective length and next pointer, zero length behaves as one
  always_comb begin
    len_eff  = (32'(len_reg) > MAX_LENGTH) ? LW'(MAX_LENGTH) : LW'(len_reg);
    nxt_full = LW'(ptr) + LW'(1);
    ptr_next = (nxt_full >= len_eff) ? '0 : PTR_W'(nxt_full);
    pos_addr = PTR_W'(issue.position);
  end

  // damped average of the two taps
  always_comb begin
    pair = (SAMPLE_BITS + 1)'(rd_cur) + (SAMPLE_BITS + 1)'(rd_nb);
    prod = XW'(pair) * XW'($signed({1'b0, damping}));
    upd  = sat(prod >>> 16);
  end

  // write port and bypass toward the word being read
  always_comb begin
    bdata   = b_tick ? upd : b_xdata;
    we      = ctl.clr || (ctl.b_go && b_wen);
    waddr   = ctl.clr ? clr_addr : b_waddr;
    wdata   = ctl.clr ? '0 : bdata;
    fwd_cur = ctl.b_go && b_wen && (b_waddr == ptr);
    fwd_nb  = ctl.b_go && b_wen && (b_waddr == ptr_next);
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.accept && issue.tick) begin
      rd_cur <= fwd_cur ? bdata : mem[ptr];
      rd_nb  <= fwd_nb ? bdata : mem[ptr_next];
    end
  end

  // read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctl.accept && issue.tick) begin
      ptr <= ptr_next;
    end
  end

  // stage b payload
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      b_tick  <= issue.tick;
      b_wen   <= issue.tick || issue.pluck;
      b_waddr <= issue.tick ? ptr : pos_addr;
      b_xdata <= sat(XW'($signed(issue.excitation)));
    end
  end

  assign cur = rd_cur;

endmodule

// ===== rtl/core/pss_mix.sv =====
// ----------------------------------------------------------------------------
// pss_mix
// Sums the voice samples, applies the output gain and saturates the result.
// ----------------------------------------------------------------------------
module pss_mix import pss_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] cur [VOICES],
  input  logic [GAIN_W-1:0]             gain,
  output logic signed [OUT_W-1:0]       mix
);

  localparam int SW = SAMPLE_BITS + VOICE_BITS;
  localparam int PW = SW + GAIN_W + 1;

  logic signed [SW-1:0] sum;
  logic signed [PW-1:0] prod, scaled;

  // sum, gain, floor shift and clamp
  always_comb begin
    sum = '0;
    for (int v = 0; v < VOICES; v++) begin
      sum = sum + SW'(cur[v]);
    end
    prod   = PW'(sum) * PW'($signed({1'b0, gain}));
    scaled = prod >>> 15;
    priority if (scaled > PW'(OUT_MAX)) mix = OUT_MAX;
    else if (scaled < -PW'(OUT_MAX))    mix = -OUT_MAX;
    else                                mix = OUT_W'(scaled);
  end

endmodule

// ===== rtl/core/plucked_string_synth_voices_core.sv =====
// ----------------------------------------------------------------------------
// plucked_string_synth_voices_core
// Four-voice plucked-string synthesizer: ticks step every ring and produce
// one mixed sample, plucks load one excitation sample into a ring.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------
//   in      | in_valid / in_ready  | op, voice, position, excitation
//   out     | out_valid / out_ready| sample_out
//   config  | apb psel / penable   | paddr, pwdata, prdata
//
// One word is taken every clock while no clearing pass runs and stage b
// can move on; a tick's sample passes from stage b into the output register.
// The rate is set by each voice's ring memory, which does two reads and one
// write per clock, with a bypass from the word ahead.
// After reset a clearing pass zeroes every address of all rings, with
// in_ready low; config writes are taken throughout.
// A stalled output holds the tick in stage b and the word behind it; a pluck
// in stage b moves on without waiting for out_ready.
// ----------------------------------------------------------------------------
module plucked_string_synth_voices_core import pss_pkg::*; #(
  parameter int MAX_LENGTH  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    op,
  input  logic [VOICE_BITS-1:0]   voice,
  input  logic [POS_W-1:0]        position,
  input  logic signed [EXC_W-1:0] excitation,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] sample_out
);

  localparam int PTR_W = $clog2(MAX_LENGTH);

  logic [LEN_REG_W-1:0] len_reg [VOICES];
  logic [DAMP_W-1:0]    damping;
  logic [GAIN_W-1:0]    gain;

  logic                 clr_busy;
  logic [PTR_W-1:0]     clr_addr;
  logic                 b_valid, b_tick, b_go, out_free, accept, cfg_we, pos_ok;
  lane_ctl_t            ctl;
  issue_t               lane_issue [VOICES];
  logic signed [SAMPLE_BITS-1:0] cur [VOICES];
  logic signed [OUT_W-1:0]       mix;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg[0] <= LEN0_RST;
      len_reg[1] <= LEN1_RST;
      len_reg[2] <= LEN2_RST;
      len_reg[3] <= LEN3_RST;
      damping    <= DAMP_RST;
      gain       <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_LEN0: len_reg[0] <= pwdata[LEN_REG_W-1:0];
        REG_LEN1: len_reg[1] <= pwdata[LEN_REG_W-1:0];
        REG_LEN2: len_reg[2] <= pwdata[LEN_REG_W-1:0];
        REG_LEN3: len_reg[3] <= pwdata[LEN_REG_W-1:0];
        REG_DAMP: damping    <= pwdata[DAMP_W-1:0];
        REG_GAIN: gain       <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_LEN0: prdata = DATA_W'(len_reg[0]);
      REG_LEN1: prdata = DATA_W'(len_reg[1]);
      REG_LEN2: prdata = DATA_W'(len_reg[2]);
      REG_LEN3: prdata = DATA_W'(len_reg[3]);
      REG_DAMP: prdata = DATA_W'(damping);
      REG_GAIN: prdata = DATA_W'(gain);
      default:  prdata = '0;
    endcase
  end

  // ring clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + PTR_W'(1);
      if (clr_addr == PTR_W'(MAX_LENGTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // handshake and stage b control
  assign out_free = !out_valid || out_ready;
  assign b_go     = b_valid && (!b_tick || out_free);
  assign in_ready = !clr_busy && (!b_valid || b_go);
  assign accept   = in_valid && in_ready;
  assign pos_ok   = 32'(position) < MAX_LENGTH;

  always_comb begin
    ctl.accept = accept;
    ctl.b_go   = b_go;
    ctl.clr    = clr_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_tick <= (op == OP_TICK);
    end
  end

  // voice lanes
  for (genvar g = 0; g < VOICES; g++) begin : g_lane
    always_comb begin
      lane_issue[g].tick       = (op == OP_TICK);
      lane_issue[g].pluck      = (op == OP_PLUCK) && (voice == VOICE_BITS'(g)) && pos_ok;
      lane_issue[g].position   = position;
      lane_issue[g].excitation = excitation;
    end

    pss_ring #(
      .MAX_LENGTH (MAX_LENGTH),
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ring (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .issue   (lane_issue[g]),
      .clr_addr(clr_addr),
      .len_reg (len_reg[g]),
      .damping (damping),
      .cur     (cur[g])
    );
  end

  // mixer
  pss_mix #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mix (
    .cur (cur),
    .gain(gain),
    .mix (mix)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && b_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_tick) begin
      sample_out <= mix;
    end
  end

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready)
    else $error("word taken during ring clearing");

  a_out_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_out != 16'sh8000))
    else $error("output sample outside saturation range");

  a_out_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_go && b_tick))
    else $error("output word without a tick leaving stage b");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_go) |=> (b_valid && $stable(b_tick)))
    else $error("stalled stage b word lost");

endmodule

// ===== bench/tb_plucked_string_synth_voices_core.sv =====
// ----------------------------------------------------------------------------
// tb_plucked_string_synth_voices_core
// Self-checking bench for the four-voice plucked-string core. A directed table
// covers silence after reset, excitation extremes, degenerate and clipped ring
// lengths, saturating damping and gain, and writes to unmapped registers.
// Random phases then retune every register and mix pluck bursts, stray plucks
// and tick runs. Each tick word is predicted by a bit-accurate ring model and
// each output sample is compared in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_plucked_string_synth_voices_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  localparam int MAX_LEN        = 256;
  // indexes past the register map
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS   = 850;
  localparam int RANDOM_PHASES  = 8;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int IDLE_LIMIT     = 4000;
  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -32768;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t         kind;
    logic [2:0]        reg_idx;
    logic [DATA_W-1:0] reg_val;
    logic              op_f;
    logic [1:0]        voice_f;
    logic [POS_W-1:0]  pos_f;
    logic [EXC_W-1:0]  exc_f;
    logic              known;
    logic [OUT_W-1:0]  known_val;
  } dir_row_t;

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_ready;
  logic                    op;
  logic [VOICE_BITS-1:0]   voice;
  logic [POS_W-1:0]        position;
  logic signed [EXC_W-1:0] excitation;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] sample_out;

  // ring model state and register copy
  logic [LEN_REG_W-1:0]    len_reg [VOICES];
  logic [DAMP_W-1:0]       damp_reg;
  logic [GAIN_W-1:0]       gain_reg;
  logic signed [15:0]      string_mem [VOICES][MAX_LEN];
  logic [7:0]              string_ptr [VOICES];
  logic signed [OUT_W-1:0] exp_samples [$];
  dir_row_t                dir_rows [$];

  int error_count  = 0;
  bit hold_pending = 1'b0;
  bit sender_calm  = 1'b0;

  plucked_string_synth_voices_core u_top (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // effective ring length of a voice
  function automatic int ring_len(int v);
    int len;
    len = len_reg[v];
    if (len < 1) len = 1;
    if (len > MAX_LEN) len = MAX_LEN;
    return len;
  endfunction

  function automatic logic signed [15:0] clamp_word(longint x, longint lo, longint hi);
    longint c;
    c = (x < lo) ? lo : ((x > hi) ? hi : x);
    return c[15:0];
  endfunction

  // one tick: step every ring, return the mixed sample
  function automatic logic signed [OUT_W-1:0] mix_strings();
    longint mix, cur, nb, damp, gain;
    int len, p, n;
    mix  = 0;
    damp = damp_reg;
    gain = gain_reg;
    for (int v = 0; v < VOICES; v++) begin
      len = ring_len(v);
      p   = string_ptr[v];
      n   = p + 1;
      if (n >= len) n = 0;
      cur = string_mem[v][p];
      nb  = string_mem[v][n];
      mix += cur;
      string_mem[v][p] = clamp_word(((cur + nb) * damp) >>> 16, SAMPLE_MIN, SAMPLE_MAX);
      string_ptr[v] = 8'(n);
    end
    return clamp_word((mix * gain) >>> 15, -longint'(OUT_MAX), longint'(OUT_MAX));
  endfunction

  function automatic void set_register(logic [2:0] idx, logic [DATA_W-1:0] val);
    case (idx)
      REG_LEN0: len_reg[0] = val[LEN_REG_W-1:0];
      REG_LEN1: len_reg[1] = val[LEN_REG_W-1:0];
      REG_LEN2: len_reg[2] = val[LEN_REG_W-1:0];
      REG_LEN3: len_reg[3] = val[LEN_REG_W-1:0];
      REG_DAMP: damp_reg   = val[DAMP_W-1:0];
      REG_GAIN: gain_reg   = val[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // directed table rows
  function automatic dir_row_t word_row(logic o, logic [1:0] v, logic [7:0] p,
                                        logic [15:0] e);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.op_f = o;
    r.voice_f = v;
    r.pos_f = p;
    r.exc_f = e;
    return r;
  endfunction

  function automatic dir_row_t known_tick(logic [15:0] val);
    dir_row_t r;
    r = word_row(OP_TICK, 2'd0, 8'd0, 16'h0000);
    r.known = 1'b1;
    r.known_val = val;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [2:0] idx, logic [31:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // random register values, extremes included
  function automatic logic [31:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd1;
    if (r == 2) return 32'd2;
    if (r == 3) return 32'd256;
    if (r == 4) return $urandom_range(257, 511);
    if (r < 10) return $urandom_range(3, 16);
    return $urandom_range(17, 256);
  endfunction

  function automatic logic [31:0] pick_damping();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd32768;
    if (r == 2) return $urandom_range(32769, 65535);
    if (r == 3) return $urandom_range(0, 65535);
    return $urandom_range(30000, 32768);
  endfunction

  function automatic logic [31:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd32767;
    if (r == 2) return 32'd16384;
    return $urandom_range(1, 16384);
  endfunction

  // gap lengths: mostly short, a few long
  function automatic int sender_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  // offer one word, predict it once taken
  task automatic send_word(logic op_v, logic [1:0] v, logic [7:0] p, logic [15:0] e,
                           logic known = 1'b0, logic [15:0] known_val = '0);
    int gap;
    logic signed [OUT_W-1:0] s;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    op         = op_v;
    voice      = v;
    position   = p;
    excitation = e;
    do @(posedge clk); while (!in_ready);
    if (op_v == OP_PLUCK) begin
      string_mem[v][p] = e;
    end else begin
      s = mix_strings();
      exp_samples.push_back(known ? known_val : s);
    end
  endtask

  // drop valid and let every expected sample drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup then access
  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    set_register(idx, val);
  endtask

  // receiver: random stalls, calm windows, one long hold on request
  initial begin : receiver
    int stall, window;
    bit calm;
    stall = 0;
    window = 0;
    calm = 1'b0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      if (window == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        window = $urandom_range(16, 96);
      end
      window--;
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 3) == 0) stall = stall_len();
      out_ready = (stall == 0);
    end
  end

  // compare each output word with the oldest expected sample
  always @(posedge clk) begin : check_samples
    logic signed [OUT_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (exp_samples.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with no sample expected", sample_out));
      end else begin
        want = exp_samples.pop_front();
        if (sample_out !== want)
          report_mismatch($sformatf("sample_out got %0d expected %0d", sample_out, want));
      end
    end
  end

  // watchdog: cycles without any word moving
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("plucked_string_synth_voices_core test failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int sent, quota, sel, run, burst, start;
    bit drained;
    logic [1:0] v;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    op = OP_TICK;
    voice = '0;
    position = '0;
    excitation = '0;
    drained = 1'b0;
    quota = RANDOM_ITEMS / RANDOM_PHASES;

    // model reset state
    len_reg[0] = LEN0_RST;
    len_reg[1] = LEN1_RST;
    len_reg[2] = LEN2_RST;
    len_reg[3] = LEN3_RST;
    damp_reg = DAMP_RST;
    gain_reg = GAIN_RST;
    for (int i = 0; i < VOICES; i++) begin
      string_ptr[i] = '0;
      for (int j = 0; j < MAX_LEN; j++) string_mem[i][j] = '0;
    end

    // directed table
    dir_rows.push_back(known_tick(16'h0000));  // rings silent after clearing
    dir_rows.push_back(word_row(OP_PLUCK, 2'd0, 8'd1, 16'h7fff));
    dir_rows.push_back(word_row(OP_PLUCK, 2'd1, 8'd1, 16'h8000));
    dir_rows.push_back(word_row(OP_PLUCK, 2'd2, 8'd255, 16'hffff));  // past ring end
    dir_rows.push_back(word_row(OP_PLUCK, 2'd3, 8'd2, 16'h5a5a));
    repeat (3) dir_rows.push_back(word_row(OP_TICK, 2'd0, 8'd0, 16'h0000));
    // length zero and one, pointers left past the new end
    dir_rows.push_back(reg_row(REG_LEN0, 32'd0));
    dir_rows.push_back(reg_row(REG_LEN1, 32'd1));
    dir_rows.push_back(reg_row(REG_LEN2, 32'd256));
    dir_rows.push_back(reg_row(REG_LEN3, 32'd511));       // clipped to max length
    dir_rows.push_back(reg_row(REG_DAMP, 32'h0000_ffff));  // updates saturate
    dir_rows.push_back(reg_row(REG_GAIN, 32'h0000_7fff));
    dir_rows.push_back(word_row(OP_PLUCK, 2'd0, 8'd0, 16'h7fff));
    dir_rows.push_back(word_row(OP_PLUCK, 2'd1, 8'd0, 16'h7fff));
    dir_rows.push_back(word_row(OP_PLUCK, 2'd2, 8'd4, 16'h7fff));
    dir_rows.push_back(word_row(OP_PLUCK, 2'd3, 8'd4, 16'h7fff));
    repeat (3) dir_rows.push_back(word_row(OP_TICK, 2'd0, 8'd0, 16'h0000));
    // all voices at the negative rail
    dir_rows.push_back(word_row(OP_PLUCK, 2'd0, 8'd0, 16'h8000));
    dir_rows.push_back(word_row(OP_PLUCK, 2'd1, 8'd0, 16'h8000));
    dir_rows.push_back(word_row(OP_PLUCK, 2'd2, 8'd7, 16'h8000));
    dir_rows.push_back(word_row(OP_PLUCK, 2'd3, 8'd7, 16'h8000));
    repeat (2) dir_rows.push_back(word_row(OP_TICK, 2'd0, 8'd0, 16'h0000));
    // lossless damping, muted output
    dir_rows.push_back(reg_row(REG_DAMP, 32'd32768));
    dir_rows.push_back(reg_row(REG_GAIN, 32'd0));
    repeat (2) dir_rows.push_back(known_tick(16'h0000));
    // no register behind these
    dir_rows.push_back(reg_row(REG_SPARE_A, 32'hffff_ffff));
    dir_rows.push_back(reg_row(REG_SPARE_B, 32'h0000_0001));
    dir_rows.push_back(reg_row(REG_GAIN, 32'd16384));
    repeat (2) dir_rows.push_back(word_row(OP_TICK, 2'd0, 8'd0, 16'h0000));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_word(dir_rows[i].op_f, dir_rows[i].voice_f, dir_rows[i].pos_f,
                  dir_rows[i].exc_f, dir_rows[i].known, dir_rows[i].known_val);
      end
    end

    // random phases, each with fresh register settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_LEN0, pick_length());
      write_reg(REG_LEN1, pick_length());
      write_reg(REG_LEN2, pick_length());
      write_reg(REG_LEN3, pick_length());
      write_reg(REG_DAMP, pick_damping());
      write_reg(REG_GAIN, pick_gain());
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_A, $urandom());
      sender_calm = ($urandom_range(0, 3) == 0);
      sent = 0;

      // long output hold while ticks keep coming
      if (ph == 1) begin
        hold_pending = 1'b1;
        repeat (24) begin
          send_word(OP_TICK, 2'($urandom), 8'($urandom), 16'($urandom));
          sent++;
        end
      end

      while (sent < quota) begin
        // sender pause until the pipe is empty
        if (ph == 3 && !drained && sent >= quota / 2) begin
          drained = 1'b1;
          wait_idle();
        end
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
          // fill a stretch of one ring with noise
          v = 2'($urandom);
          start = $urandom_range(0, ring_len(v) - 1);
          burst = $urandom_range(2, 24);
          for (int k = 0; k < burst; k++) begin
            send_word(OP_PLUCK, v, 8'(start + k), 16'($urandom));
            sent++;
          end
        end else if (sel < 4) begin
          send_word(OP_PLUCK, 2'($urandom), 8'($urandom), 16'($urandom));
          sent++;
        end else begin
          run = $urandom_range(1, 24);
          repeat (run) begin
            send_word(OP_TICK, 2'($urandom), 8'($urandom), 16'($urandom));
            sent++;
          end
        end
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("plucked_string_synth_voices_core test passed");
    end else begin
      $display("plucked_string_synth_voices_core test failed");
    end
    $finish;
  end

endmodule
